// ----- design/ezr_pkg.sv -----
// ezr_pkg: shared constants, types and helper functions for the euler zyx
// to rotation matrix core; no dependencies
`default_nettype none
package ezr_pkg;
    localparam int IN_W         = 16;
    localparam int IN_FRAC      = 13;
    localparam int WORK_FRAC    = 30;
    localparam int WORK_W       = 33;
    localparam int OUT_W        = 16;
    localparam int MAX_STEPS    = 24;
    localparam int DEF_STEPS    = 16;
    localparam int DEF_ANGLE_W  = 16;
    localparam int HALF_PI_IN   = 12868;
    localparam int PI_IN        = 25736;
    localparam longint GAIN_LIMIT = 64'sd652032874;
    localparam longint GAIN_TAIL  = 64'sd434688583;
    localparam int ONE_OUT      = 16384;
    localparam int QUEUE_DEPTH  = 4;

    typedef logic signed [WORK_W-1:0] t_work;

    typedef struct packed {
        logic signed [IN_W-1:0] yaw;
        logic signed [IN_W-1:0] pitch;
        logic signed [IN_W-1:0] roll;
    } t_angles;

    function automatic longint atan_entry(input int i);
        longint tab [MAX_STEPS];
        tab = '{64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
                64'd67021687, 64'd33543516, 64'd16775851, 64'd8388437,
                64'd4194283, 64'd2097149, 64'd1048576, 64'd524288, 64'd262144,
                64'd131072, 64'd65536, 64'd32768, 64'd16384, 64'd8192,
                64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256, 64'd128};
        return tab[i];
    endfunction

    // atan(2^-i) rounded half up to afrac fraction bits
    function automatic longint atan_scaled(input int i, input int afrac);
        int s;
        s = WORK_FRAC - afrac;
        if (s == 0) return atan_entry(i);
        return (atan_entry(i) + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // fixed point product of two 30-fraction values, rounded half up
    function automatic t_work fmul(input t_work a, input t_work b);
        logic signed [2*WORK_W-1:0] p;
        p = a * b + (66'sd1 <<< (WORK_FRAC - 1));
        return t_work'(p >>> WORK_FRAC);
    endfunction

    // round to 14 fraction bits and saturate to plus or minus one
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [WORK_W+1:0] v);
        logic signed [WORK_W+1:0] r;
        r = (v + (35'sd1 <<< (WORK_FRAC - 15))) >>> (WORK_FRAC - 14);
        if (r > ONE_OUT) return OUT_W'(ONE_OUT);
        if (r < -ONE_OUT) return OUT_W'(-ONE_OUT);
        return r[OUT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/ezr_front.sv -----
// ezr_front: fold and rescale of the three angles, then a pipelined cordic
// giving sine and cosine; depends on ezr_pkg
`default_nettype none
module ezr_front #(
    parameter int CORDIC_STEPS = ezr_pkg::DEF_STEPS,
    parameter int ANGLE_BITS   = ezr_pkg::DEF_ANGLE_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire ezr_pkg::t_angles     i_ang,
    output logic                      o_valid,
    output ezr_pkg::t_work            o_cs [6]
);
    import ezr_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int AFRAC = ANGLE_BITS - 3;
    localparam int ZW    = ANGLE_BITS + 2;
    localparam longint KINIT = GAIN_LIMIT + (GAIN_TAIL >>> (2 * STEPS));

    logic                 r_vld  [STEPS+1];
    t_work                r_x    [STEPS+1][3];
    t_work                r_y    [STEPS+1][3];
    logic signed [ZW-1:0] r_z    [STEPS+1][3];
    logic                 r_flip [STEPS+1][3];

    logic signed [IN_W-1:0] w_raw [3];
    assign w_raw[0] = i_ang.yaw;
    assign w_raw[1] = i_ang.pitch;
    assign w_raw[2] = i_ang.roll;

    // stage 0: half-turn fold and rescale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ang
        logic signed [IN_W+1:0] w_f;
        logic                   w_fl;
        logic signed [ZW-1:0]   w_z;
        always_comb begin
            w_f  = (IN_W+2)'(w_raw[a]);
            w_fl = 1'b0;
            if (w_raw[a] > HALF_PI_IN) begin
                w_f  = (IN_W+2)'(w_raw[a]) - (IN_W+2)'(PI_IN);
                w_fl = 1'b1;
            end else if (w_raw[a] < -HALF_PI_IN) begin
                w_f  = (IN_W+2)'(w_raw[a]) + (IN_W+2)'(PI_IN);
                w_fl = 1'b1;
            end
            if (AFRAC >= IN_FRAC) begin
                w_z = ZW'(w_f) <<< (AFRAC >= IN_FRAC ? AFRAC - IN_FRAC : 0);
            end else begin
                w_z = ZW'((w_f + ((IN_W+2)'(1) <<< (AFRAC < IN_FRAC ? IN_FRAC-AFRAC-1 : 0)))
                      >>> (AFRAC < IN_FRAC ? IN_FRAC - AFRAC : 0));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0][a]    <= t_work'(KINIT);
                r_y[0][a]    <= '0;
                r_z[0][a]    <= w_z;
                r_flip[0][a] <= w_fl;
            end
        end

        // one micro-rotation per stage
        for (genvar i = 0; i < STEPS; i++) begin : g_st
            localparam logic signed [ZW-1:0] DA = ZW'(atan_scaled(i, AFRAC));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_flip[i+1][a] <= r_flip[i][a];
                    if (!r_z[i][a][ZW-1]) begin
                        r_x[i+1][a] <= r_x[i][a] - (r_y[i][a] >>> i);
                        r_y[i+1][a] <= r_y[i][a] + (r_x[i][a] >>> i);
                        r_z[i+1][a] <= r_z[i][a] - DA;
                    end else begin
                        r_x[i+1][a] <= r_x[i][a] + (r_y[i][a] >>> i);
                        r_y[i+1][a] <= r_y[i][a] - (r_x[i][a] >>> i);
                        r_z[i+1][a] <= r_z[i][a] + DA;
                    end
                end
            end
        end

        assign o_cs[2*a]   = r_flip[STEPS][a] ? -r_x[STEPS][a] : r_x[STEPS][a];
        assign o_cs[2*a+1] = r_flip[STEPS][a] ? -r_y[STEPS][a] : r_y[STEPS][a];
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    assign o_valid = r_vld[STEPS];
endmodule
`default_nettype wire

// ----- design/ezr_queue.sv -----
// ezr_queue: short fifo of sine and cosine sets between front and back
// depends on ezr_pkg
`default_nettype none
module ezr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ezr_pkg::t_work i_d [6],
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic [$clog2(ezr_pkg::QUEUE_DEPTH):0] o_count,
    output ezr_pkg::t_work      o_d [6]
);
    import ezr_pkg::*;
    localparam int AW = $clog2(QUEUE_DEPTH);

    t_work        r_mem [QUEUE_DEPTH][6];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_count = r_cnt;
    assign o_d     = r_mem[r_rp];
endmodule
`default_nettype wire

// ----- design/ezr_back.sv -----
// ezr_back: pipelined products, sums and output rounding of the nine
// matrix elements with an output register; depends on ezr_pkg
`default_nettype none
module ezr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire ezr_pkg::t_work i_cs [6],
    output logic                o_ready,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic signed [ezr_pkg::OUT_W-1:0] o_m [9]
);
    import ezr_pkg::*;

    // cs order: cz sz cy sy cx sx
    logic  r_v1, r_v2, r_v3;
    t_work r_czcy, r_szcy, r_czsy, r_szsy, r_szcx, r_szsx, r_czcx, r_czsx;
    t_work r_cysx, r_cycx, r_sy, r_cx, r_sx;
    t_work r_p [9];
    t_work r_s01, r_s02, r_s11, r_s12;
    logic  w_en;

    assign w_en    = !(r_v3 && i_stall);
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_czcy <= fmul(i_cs[0], i_cs[2]);
            r_szcy <= fmul(i_cs[1], i_cs[2]);
            r_czsy <= fmul(i_cs[0], i_cs[3]);
            r_szsy <= fmul(i_cs[1], i_cs[3]);
            r_szcx <= fmul(i_cs[1], i_cs[4]);
            r_szsx <= fmul(i_cs[1], i_cs[5]);
            r_czcx <= fmul(i_cs[0], i_cs[4]);
            r_czsx <= fmul(i_cs[0], i_cs[5]);
            r_cysx <= fmul(i_cs[2], i_cs[5]);
            r_cycx <= fmul(i_cs[2], i_cs[4]);
            r_sy   <= i_cs[3];
            r_cx   <= i_cs[4];
            r_sx   <= i_cs[5];
            // second product layer
            r_p[0] <= r_czcy;
            r_p[1] <= fmul(r_czsy, r_sx);
            r_p[2] <= fmul(r_czsy, r_cx);
            r_p[3] <= r_szcy;
            r_p[4] <= fmul(r_szsy, r_sx);
            r_p[5] <= fmul(r_szsy, r_cx);
            r_p[6] <= -r_sy;
            r_p[7] <= r_cysx;
            r_p[8] <= r_cycx;
            r_s01  <= r_szcx;
            r_s02  <= r_szsx;
            r_s11  <= r_czcx;
            r_s12  <= r_czsx;
            // sums and output rounding
            o_m[0] <= to_out((WORK_W+2)'(r_p[0]));
            o_m[1] <= to_out((WORK_W+2)'(r_p[1]) - (WORK_W+2)'(r_s01));
            o_m[2] <= to_out((WORK_W+2)'(r_p[2]) + (WORK_W+2)'(r_s02));
            o_m[3] <= to_out((WORK_W+2)'(r_p[3]));
            o_m[4] <= to_out((WORK_W+2)'(r_p[4]) + (WORK_W+2)'(r_s11));
            o_m[5] <= to_out((WORK_W+2)'(r_p[5]) - (WORK_W+2)'(r_s12));
            o_m[6] <= to_out((WORK_W+2)'(r_p[6]));
            o_m[7] <= to_out((WORK_W+2)'(r_p[7]));
            o_m[8] <= to_out((WORK_W+2)'(r_p[8]));
        end
    end

    assign o_valid = r_v3;
endmodule
`default_nettype wire

// ----- design/euler_zyx_to_rotation_matrix_core.sv -----
// euler_zyx_to_rotation_matrix_core: top level, cordic front, fifo and
// product back end; depends on ezr_pkg, ezr_front, ezr_queue, ezr_back
//
// usage
//   input channel: i_valid with the three angles (13 fraction bits), o_stall
//   output channel: o_valid with nine matrix elements (14 fraction bits),
//   i_stall from the receiver
//   one request accepted per cycle while the queue has room
//   path: the fold and rescale stage and the cordic stages, then the
//   queue, then the product, second product and sum stages of the back end
//   throughput: one request per cycle while nothing stalls, set by the fully
//   pipelined cordic stages and at most one multiplier layer per back stage
//   the cordic pipe advances as a whole; it holds, and o_stall rises, only
//   while its last stage carries a request and the queue is full
//   when the receiver stalls the back end holds its three stages and the
//   queue fills; results are never dropped
//   reset (synchronous, active low) empties the pipes and the queue
`default_nettype none
module euler_zyx_to_rotation_matrix_core #(
    parameter int CORDIC_STEPS = ezr_pkg::DEF_STEPS,
    parameter int ANGLE_BITS   = ezr_pkg::DEF_ANGLE_W
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire logic signed [ezr_pkg::IN_W-1:0] i_yaw_angle,
    input  wire logic signed [ezr_pkg::IN_W-1:0] i_pitch_angle,
    input  wire logic signed [ezr_pkg::IN_W-1:0] i_roll_angle,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic signed [ezr_pkg::OUT_W-1:0] o_m00, o_m01, o_m02,
    output logic signed [ezr_pkg::OUT_W-1:0] o_m10, o_m11, o_m12,
    output logic signed [ezr_pkg::OUT_W-1:0] o_m20, o_m21, o_m22
);
    import ezr_pkg::*;
    localparam int CW = $clog2(QUEUE_DEPTH) + 1;

    t_angles w_ang;
    t_work   w_cs [6];
    t_work   w_qd [6];
    logic    w_fv, w_qv, w_ready, w_pop, w_en, w_push, w_full;
    logic [CW-1:0] w_cnt;
    logic signed [OUT_W-1:0] w_m [9];

    assign w_ang = '{yaw: i_yaw_angle, pitch: i_pitch_angle, roll: i_roll_angle};

    // the cordic pipe holds while its last stage waits on a full queue
    assign w_full  = (w_cnt == CW'(QUEUE_DEPTH));
    assign w_en    = !(w_fv && w_full);
    assign o_stall = !w_en;

    ezr_front #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_valid && !o_stall),
        .i_ang(w_ang), .o_valid(w_fv), .o_cs(w_cs)
    );

    assign w_push = w_fv && w_en;
    assign w_pop  = w_qv && w_ready;

    ezr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_d(w_cs), .i_pop(w_pop),
        .o_valid(w_qv), .o_count(w_cnt), .o_d(w_qd)
    );

    ezr_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_pop), .i_cs(w_qd), .o_ready(w_ready),
        .i_stall, .o_valid, .o_m(w_m)
    );

    assign o_m00 = w_m[0]; assign o_m01 = w_m[1]; assign o_m02 = w_m[2];
    assign o_m10 = w_m[3]; assign o_m11 = w_m[4]; assign o_m12 = w_m[5];
    assign o_m20 = w_m[6]; assign o_m21 = w_m[7]; assign o_m22 = w_m[8];
endmodule
`default_nettype wire

// ----- design/ezr_checker.sv -----
// ezr_checker: port-level assertions for the core, bound to the top level
// depends on euler_zyx_to_rotation_matrix_core ports only
`default_nettype none
module ezr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_stall,
    input wire logic signed [15:0] o_m00, o_m20, o_m22
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_m00) && $stable(o_m22))
        else $error("stalled result changed");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_m00 <= 16384 && o_m00 >= -16384 &&
                     o_m20 <= 16384 && o_m20 >= -16384))
        else $error("element out of range");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear");
endmodule

bind euler_zyx_to_rotation_matrix_core ezr_checker u_ezr_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_stall, .o_m00, .o_m20, .o_m22
);
`default_nettype wire

// ----- bench/tb_euler_zyx_to_rotation_matrix_core.sv -----
// tb_euler_zyx_to_rotation_matrix_core: self-checking bench for the euler zyx
// rotation matrix core; depends on ezr_pkg and euler_zyx_to_rotation_matrix_core
`timescale 1ns / 1ps
`default_nettype none
module tb_euler_zyx_to_rotation_matrix_core;
    import ezr_pkg::*;

    localparam int STEPS   = DEF_STEPS;
    localparam int ANG_W   = DEF_ANGLE_W;
    localparam int N_RAND  = 1000;
    localparam int LIMIT   = 200000;

    typedef logic signed [15:0] t_elem;
    typedef struct {
        t_elem m [9];
    } t_matrix;

    // arithmetic shift right, floor
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shr(a * b, WORK_FRAC);
    endfunction

    function automatic t_elem quantize(longint v);
        longint r;
        r = round_shr(v, WORK_FRAC - 14);
        if (r > ONE_OUT) r = ONE_OUT;
        if (r < -ONE_OUT) r = -ONE_OUT;
        return t_elem'(r);
    endfunction

    // cordic sine and cosine of one angle, after the half-turn fold
    function automatic void cordic_sincos(input logic signed [15:0] ang,
                                          output longint c, output longint s);
        longint a, x, y, z, dx, dy, da, tab [MAX_STEPS];
        int afrac;
        bit flip;
        tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128};
        afrac = ANG_W - 3;
        a = ang;
        flip = 0;
        if (a > HALF_PI_IN) begin
            a -= PI_IN; flip = 1;
        end else if (a < -HALF_PI_IN) begin
            a += PI_IN; flip = 1;
        end
        if (afrac >= IN_FRAC) z = a <<< (afrac - IN_FRAC);
        else z = round_shr(a, IN_FRAC - afrac);
        x = GAIN_LIMIT + (GAIN_TAIL >> (2 * STEPS));
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shr(x, i);
            dy = floor_shr(y, i);
            da = round_shr(tab[i], WORK_FRAC - afrac);
            if (z >= 0) begin
                x -= dy; y += dx; z -= da;
            end else begin
                x += dy; y -= dx; z += da;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x; s = y;
    endfunction

    function automatic void predict_matrix(input logic signed [15:0] yaw, pitch, roll,
                                           output t_matrix r);
        longint cz, sz, cy, sy, cx, sx, czsy, szsy;
        cordic_sincos(yaw, cz, sz);
        cordic_sincos(pitch, cy, sy);
        cordic_sincos(roll, cx, sx);
        czsy = qmul(cz, sy);
        szsy = qmul(sz, sy);
        r.m[0] = quantize(qmul(cz, cy));
        r.m[1] = quantize(qmul(czsy, sx) - qmul(sz, cx));
        r.m[2] = quantize(qmul(czsy, cx) + qmul(sz, sx));
        r.m[3] = quantize(qmul(sz, cy));
        r.m[4] = quantize(qmul(szsy, sx) + qmul(cz, cx));
        r.m[5] = quantize(qmul(szsy, cx) - qmul(cz, sx));
        r.m[6] = quantize(-sy);
        r.m[7] = quantize(qmul(cy, sx));
        r.m[8] = quantize(qmul(cy, cx));
    endfunction

    class matrix_scoreboard;
        t_matrix pending [$];
        int mismatches = 0;

        function void note_request(logic signed [15:0] yaw, pitch, roll);
            t_matrix r;
            predict_matrix(yaw, pitch, roll, r);
            pending.push_back(r);
        endfunction

        function void check_result(t_matrix got);
            t_matrix want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result");
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.m[k] !== want.m[k]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("m%0d%0d: expected %0d actual %0d",
                                 k / 3, k % 3, want.m[k], got.m[k]);
                end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic signed [15:0] i_yaw_angle = 0, i_pitch_angle = 0, i_roll_angle = 0;
    logic o_stall, o_valid;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    matrix_scoreboard sb = new();
    int cycle = 0;
    bit sending_done = 0;

    always #5 i_clk = ~i_clk;

    euler_zyx_to_rotation_matrix_core u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_yaw_angle, .i_pitch_angle, .i_roll_angle,
        .o_valid, .i_stall,
        .o_m00, .o_m01, .o_m02, .o_m10, .o_m11, .o_m12,
        .o_m20, .o_m21, .o_m22
    );

    // random angle: mostly in +-pi, sometimes any 16-bit value or a fold edge
    function automatic logic signed [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 16'(int'($urandom_range(0, 2 * PI_IN)) - PI_IN);
        if (sel < 8) return 16'($urandom);
        case ($urandom_range(0, 5))
            0: return 16'(HALF_PI_IN);
            1: return 16'(HALF_PI_IN + 1);
            2: return 16'(-HALF_PI_IN);
            3: return 16'(-HALF_PI_IN - 1);
            4: return 16'(PI_IN);
            default: return 16'(-PI_IN);
        endcase
    endfunction

    // send one request, holding it until accepted, after a random gap
    task automatic send_request(logic signed [15:0] yaw, pitch, roll);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_yaw_angle <= yaw;
        i_pitch_angle <= pitch;
        i_roll_angle <= roll;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge
        sb.note_request(yaw, pitch, roll);
    endtask

    // receiver: random stalls of random length, with stall-free stretches
    initial begin
        int wait_n;
        t_matrix got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.m = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12,
                          o_m20, o_m21, o_m22};
                sb.check_result(got);
            end
            if (i_stall) begin
                if (wait_n > 0) wait_n--;
                if (wait_n == 0) i_stall <= 0;
            end else if ((cycle / 2000) % 2 == 1 && $urandom_range(0, 3) == 0) begin
                wait_n = $urandom_range(1, 6);
                i_stall <= 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] edges [10];
        edges = '{16'sh7fff, -16'sh8000, 16'sd0, 16'(PI_IN), 16'(-PI_IN),
                  16'(HALF_PI_IN), 16'(HALF_PI_IN + 1), 16'(-HALF_PI_IN),
                  16'(-HALF_PI_IN - 1), 16'sd1};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: each edge angle on yaw, then on pitch and roll together, then extremes and one mixed set
        foreach (edges[k]) send_request(edges[k], 16'sd0, 16'sd0);
        foreach (edges[k]) send_request(16'sd0, edges[k], edges[k]);
        send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_request(-16'sh8000, -16'sh8000, -16'sh8000);
        send_request(16'(PI_IN), -16'(HALF_PI_IN), 16'(HALF_PI_IN + 1));
        for (int n = 0; n < N_RAND; n++)
            send_request(pick_angle(), pick_angle(), pick_angle());
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (STEPS + 10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
